// File: src/pcbp_pkg.sv
`timescale 1ns / 1ps

package pcbp_pkg;

  // Table and field geometry
  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int SYM_W        = 8;
  localparam int SYM_AW       = $clog2(SYMBOL_COUNT);
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int ENTRY_W      = LEN_W + CODE_W;

  // Bit accumulator: up to 7 pending bits plus one code, left aligned
  localparam int ACC_W        = CODE_W + 8;
  localparam int CNT_W        = $clog2(CODE_W + 8);

  // Item kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_ENCODE = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_FULL    = 2'd0;
  localparam logic [1:0] STATUS_PARTIAL = 2'd1;
  localparam logic [1:0] STATUS_NOCODE  = 2'd2;

  // Commands handed from the front end to the packer
  typedef enum logic [1:0] {
    OP_ENCODE,
    OP_ERROR,
    OP_FLUSH
  } pcbp_op_e;

  typedef struct packed {
    pcbp_op_e          op;
    logic [CODE_W-1:0] code;  // left aligned, zero below the length
    logic [LEN_W-1:0]  len;
  } pcbp_cmd_t;

endpackage

// File: src/prefix_code_bit_packer.sv
// An encode word passes the lookup register and the two-word command queue into the
// packer's bit accumulator; whole bytes leave it through the result register.
// Throughput: the front end takes one word per cycle while full is low; the packer
// takes one command at a time and holds off the next until its whole bytes are emitted.
// Reset (async, active low) clears the pending bits, the queues and the written flags.
`timescale 1ns / 1ps

module prefix_code_bit_packer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  kind_i,
  input  logic [pcbp_pkg::SYM_W-1:0]  symbol_i,
  input  logic [pcbp_pkg::CODE_W-1:0] code_bits_i,
  input  logic [pcbp_pkg::LEN_W-1:0]  code_length_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  byte_out_o,
  output logic [3:0]                  valid_bits_o,
  output logic [1:0]                  status_o,
  output logic                        last_o
);

  logic                f_valid;
  logic                f_ready;
  pcbp_pkg::pcbp_cmd_t f_cmd;
  logic                b_valid;
  logic                b_pop;
  pcbp_pkg::pcbp_cmd_t b_cmd;

  pcbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .kind_i        (kind_i),
    .symbol_i      (symbol_i),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .cmd_valid_o   (f_valid),
    .cmd_ready_i   (f_ready),
    .cmd_o         (f_cmd)
  );

  pcbp_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_cmd_i   (f_cmd),
    .rd_valid_o (b_valid),
    .rd_pop_i   (b_pop),
    .rd_cmd_o   (b_cmd)
  );

  pcbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (b_valid),
    .cmd_pop_o    (b_pop),
    .cmd_i        (b_cmd),
    .empty        (empty),
    .pop          (pop),
    .byte_out_o   (byte_out_o),
    .valid_bits_o (valid_bits_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  // A missing code gives an all-zero final result
  a_nocode_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == pcbp_pkg::STATUS_NOCODE) |->
      (byte_out_o == 8'd0 && valid_bits_o == 4'd0 && last_o))
    else $error("no-code result with nonzero fields");

  // Full bytes always carry eight bits
  a_full_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == pcbp_pkg::STATUS_FULL) |-> (valid_bits_o == 4'd8))
    else $error("full byte without eight valid bits");

  // A flushed byte holds 1..7 bits, ends its word and is padded with zeros
  a_partial_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == pcbp_pkg::STATUS_PARTIAL) |->
      (valid_bits_o != 4'd0 && valid_bits_o < 4'd8 && last_o &&
       ((byte_out_o << valid_bits_o) == 8'd0)))
    else $error("bad partial byte");

  // Only three status codes exist
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o == pcbp_pkg::STATUS_FULL || status_o == pcbp_pkg::STATUS_PARTIAL ||
                status_o == pcbp_pkg::STATUS_NOCODE))
    else $error("undefined status code");

endmodule

// File: src/pcbp_ram.sv
`timescale 1ns / 1ps

module pcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/pcbp_front.sv
`timescale 1ns / 1ps

module pcbp_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     kind_i,
  input  logic [pcbp_pkg::SYM_W-1:0]     symbol_i,
  input  logic [pcbp_pkg::CODE_W-1:0]    code_bits_i,
  input  logic [pcbp_pkg::LEN_W-1:0]     code_length_i,
  output logic                           cmd_valid_o,
  input  logic                           cmd_ready_i,
  output pcbp_pkg::pcbp_cmd_t            cmd_o
);

  logic                              accept;
  logic                              in_range;
  logic [pcbp_pkg::SYM_AW-1:0]       addr;
  logic [pcbp_pkg::LEN_W-1:0]        len_sat;
  logic [pcbp_pkg::CODE_W:0]         mask_wide;
  logic [pcbp_pkg::CODE_W-1:0]       word_masked;
  logic                              tbl_we;
  logic                              tbl_re;
  logic [pcbp_pkg::ENTRY_W-1:0]      tbl_rdata;
  logic [pcbp_pkg::LEN_W-1:0]        rd_len;
  logic [pcbp_pkg::CODE_W-1:0]       rd_code;
  logic [pcbp_pkg::SYMBOL_COUNT-1:0] written_q;
  logic                              s1_valid_q;
  logic                              s1_flush_q;
  logic                              s1_has_q;
  logic                              s1_drain;

  assign accept   = push && !full;
  assign full     = s1_valid_q && !cmd_ready_i;
  assign in_range = {1'b0, symbol_i} < (pcbp_pkg::SYM_W + 1)'(pcbp_pkg::SYMBOL_COUNT);
  assign addr     = symbol_i[pcbp_pkg::SYM_AW-1:0];

  // Load: saturate the length and clear code bits above it
  always_comb begin
    if (code_length_i > pcbp_pkg::LEN_W'(pcbp_pkg::LEN_LIMIT)) begin
      len_sat = pcbp_pkg::LEN_W'(pcbp_pkg::LEN_LIMIT);
    end else begin
      len_sat = code_length_i;
    end
    mask_wide   = ((pcbp_pkg::CODE_W + 1)'(1) << len_sat) - (pcbp_pkg::CODE_W + 1)'(1);
    word_masked = code_bits_i & mask_wide[pcbp_pkg::CODE_W-1:0];
  end

  assign tbl_we = accept && (kind_i == pcbp_pkg::KIND_LOAD) && in_range;
  assign tbl_re = accept && (kind_i == pcbp_pkg::KIND_ENCODE);

  pcbp_ram #(
    .WIDTH (pcbp_pkg::ENTRY_W),
    .DEPTH (pcbp_pkg::SYMBOL_COUNT)
  ) u_code_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (addr),
    .wdata_i ({len_sat, word_masked}),
    .re_i    (tbl_re),
    .raddr_i (addr),
    .rdata_o (tbl_rdata)
  );

  // Written flags stand in for the table reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (tbl_we) begin
      written_q[addr] <= 1'b1;
    end
  end

  // Lookup stage: waits here for the table read and for queue space
  assign s1_drain = s1_valid_q && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept && ((kind_i == pcbp_pkg::KIND_ENCODE) ||
                            (kind_i == pcbp_pkg::KIND_FLUSH))) begin
      s1_valid_q <= 1'b1;
    end else if (s1_drain) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_flush_q <= (kind_i == pcbp_pkg::KIND_FLUSH);
      s1_has_q   <= in_range && written_q[addr];
    end
  end

  assign rd_len  = tbl_rdata[pcbp_pkg::ENTRY_W-1:pcbp_pkg::CODE_W];
  assign rd_code = tbl_rdata[pcbp_pkg::CODE_W-1:0];

  // Classify and left-align the code word
  always_comb begin
    cmd_o.code = '0;
    cmd_o.len  = '0;
    if (s1_flush_q) begin
      cmd_o.op = pcbp_pkg::OP_FLUSH;
    end else if (!s1_has_q || (rd_len == '0)) begin
      cmd_o.op = pcbp_pkg::OP_ERROR;
    end else begin
      cmd_o.op   = pcbp_pkg::OP_ENCODE;
      cmd_o.len  = rd_len;
      cmd_o.code = rd_code << (pcbp_pkg::LEN_W'(pcbp_pkg::CODE_W) - rd_len);
    end
  end

  assign cmd_valid_o = s1_valid_q;

endmodule

// File: src/pcbp_cmd_fifo.sv
`timescale 1ns / 1ps

module pcbp_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  pcbp_pkg::pcbp_cmd_t wr_cmd_i,
  output logic                rd_valid_o,
  input  logic                rd_pop_i,
  output pcbp_pkg::pcbp_cmd_t rd_cmd_o
);

  pcbp_pkg::pcbp_cmd_t entry_q [2];
  logic                wr_ptr_q;
  logic                rd_ptr_q;
  logic [1:0]          count_q;
  logic                do_wr;
  logic                do_rd;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_pop_i && rd_valid_o;
  assign rd_cmd_o   = entry_q[rd_ptr_q];

  // Two-word queue between lookup and packer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 2'd1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

// File: src/pcbp_back.sv
`timescale 1ns / 1ps

module pcbp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  input  pcbp_pkg::pcbp_cmd_t cmd_i,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          byte_out_o,
  output logic [3:0]          valid_bits_o,
  output logic [1:0]          status_o,
  output logic                last_o
);

  logic [pcbp_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [pcbp_pkg::CNT_W-1:0] total_q, total_d;
  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 byte_q, byte_d;
  logic [3:0]                 valid_bits_q, valid_bits_d;
  logic [1:0]                 status_q, status_d;
  logic                       last_q, last_d;
  logic                       out_free;

  assign out_free = !out_valid_q || pop;

  // Emit whole bytes first; otherwise take the next command
  always_comb begin
    acc_d        = acc_q;
    total_d      = total_q;
    out_valid_d  = out_valid_q && !pop;
    byte_d       = byte_q;
    valid_bits_d = valid_bits_q;
    status_d     = status_q;
    last_d       = last_q;
    cmd_pop_o    = 1'b0;
    if (total_q >= pcbp_pkg::CNT_W'(8)) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        byte_d       = acc_q[pcbp_pkg::ACC_W-1 -: 8];
        valid_bits_d = 4'd8;
        status_d     = pcbp_pkg::STATUS_FULL;
        last_d       = (total_q < pcbp_pkg::CNT_W'(16));
        acc_d        = acc_q << 8;
        total_d      = total_q - pcbp_pkg::CNT_W'(8);
      end
    end else if (cmd_valid_i) begin
      case (cmd_i.op)
        pcbp_pkg::OP_ENCODE: begin
          // pending bits stay on top, the code goes right behind them
          cmd_pop_o = 1'b1;
          acc_d     = acc_q | ({cmd_i.code, 8'd0} >> total_q[2:0]);
          total_d   = total_q + pcbp_pkg::CNT_W'(cmd_i.len);
        end
        pcbp_pkg::OP_ERROR: begin
          if (out_free) begin
            cmd_pop_o    = 1'b1;
            out_valid_d  = 1'b1;
            byte_d       = 8'd0;
            valid_bits_d = 4'd0;
            status_d     = pcbp_pkg::STATUS_NOCODE;
            last_d       = 1'b1;
          end
        end
        pcbp_pkg::OP_FLUSH: begin
          if (total_q == '0) begin
            cmd_pop_o = 1'b1;
          end else if (out_free) begin
            cmd_pop_o    = 1'b1;
            out_valid_d  = 1'b1;
            byte_d       = acc_q[pcbp_pkg::ACC_W-1 -: 8];
            valid_bits_d = {1'b0, total_q[2:0]};
            status_d     = pcbp_pkg::STATUS_PARTIAL;
            last_d       = 1'b1;
            acc_d        = '0;
            total_d      = '0;
          end
        end
        default: begin
          cmd_pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    byte_q       <= byte_d;
    valid_bits_q <= valid_bits_d;
    status_q     <= status_d;
    last_q       <= last_d;
  end

  assign empty        = !out_valid_q;
  assign byte_out_o   = byte_q;
  assign valid_bits_o = valid_bits_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule

// File: tb/sv/tb_prefix_code_bit_packer.sv
`timescale 1ns / 1ps

module tb_prefix_code_bit_packer;

  localparam logic [1:0] KIND_UNUSED = 2'd3;  // reserved kind, block drops it
  localparam int RANDOM_ITEMS = 225;
  localparam int ALPHABET_N   = 12;
  localparam int QUIET_LIMIT  = 4000;  // far above any stall of a working block
  localparam int DRAIN_CYCLES = 32;

  // Idle phases
  localparam int PH_NONE    = 0;
  localparam int PH_SENDER  = 1;
  localparam int PH_RECEIVE = 2;
  localparam int PH_BOTH    = 3;

  typedef struct {
    logic [1:0]                  kind;
    logic [pcbp_pkg::SYM_W-1:0]  symbol;
    logic [pcbp_pkg::CODE_W-1:0] code_bits;
    logic [pcbp_pkg::LEN_W-1:0]  code_length;
  } sym_item_t;

  typedef struct {
    logic [7:0] byte_val;
    logic [3:0] valid_bits;
    logic [1:0] status;
    logic       last;
  } out_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [1:0] kind_i = '0;
  logic [pcbp_pkg::SYM_W-1:0] symbol_i = '0;
  logic [pcbp_pkg::CODE_W-1:0] code_bits_i = '0;
  logic [pcbp_pkg::LEN_W-1:0] code_length_i = '0;
  logic full, empty;
  logic [7:0] byte_out_o;
  logic [3:0] valid_bits_o;
  logic [1:0] status_o;
  logic last_o;

  prefix_code_bit_packer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .kind_i        (kind_i),
    .symbol_i      (symbol_i),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .empty         (empty),
    .pop           (pop),
    .byte_out_o    (byte_out_o),
    .valid_bits_o  (valid_bits_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  always #1 clk_i = ~clk_i;

  // Encoder mirror: code table and bit accumulator
  logic [pcbp_pkg::CODE_W-1:0] code_word_tbl [pcbp_pkg::SYMBOL_COUNT];
  logic [pcbp_pkg::LEN_W-1:0]  code_len_tbl  [pcbp_pkg::SYMBOL_COUNT];
  logic [6:0]                  acc_bits;
  int unsigned                 acc_count;

  sym_item_t stim_items[$];
  out_byte_t predicted_bytes[$];

  int total_items;
  int items_sent;
  int phase;
  int errors;
  int quiet_cycles;
  int full_seen, partial_seen, nocode_seen;
  logic [7:0] alphabet [ALPHABET_N];

  // Update the mirror for one accepted word and queue the bytes it produces
  task automatic predict_item(input sym_item_t it);
    logic [63:0] acc;
    logic [7:0] tail;
    int unsigned clen;
    int unsigned total;
    int unsigned len;
    out_byte_t r;
    case (it.kind)
      pcbp_pkg::KIND_LOAD: begin
        if (int'(it.symbol) < pcbp_pkg::SYMBOL_COUNT) begin
          len = it.code_length;
          if (len > pcbp_pkg::LEN_LIMIT) len = pcbp_pkg::LEN_LIMIT;
          if (len < 32)
            code_word_tbl[it.symbol] = it.code_bits & ((32'd1 << len) - 32'd1);
          else
            code_word_tbl[it.symbol] = it.code_bits;
          code_len_tbl[it.symbol] = pcbp_pkg::LEN_W'(len);
        end
      end
      pcbp_pkg::KIND_ENCODE: begin
        if (int'(it.symbol) >= pcbp_pkg::SYMBOL_COUNT ||
            code_len_tbl[it.symbol] == 0) begin
          r = '{8'h00, 4'd0, pcbp_pkg::STATUS_NOCODE, 1'b1};
          predicted_bytes = {predicted_bytes, r};
        end else begin
          clen = code_len_tbl[it.symbol];
          acc = (64'(acc_bits) << clen) | 64'(code_word_tbl[it.symbol]);
          total = acc_count + clen;
          while (total >= 8) begin
            total -= 8;
            r.byte_val = acc[total +: 8];
            r.valid_bits = 4'd8;
            r.status = pcbp_pkg::STATUS_FULL;
            r.last = (total < 8);
            predicted_bytes = {predicted_bytes, r};
          end
          acc_count = total;
          acc_bits = 7'(acc & ((64'd1 << total) - 64'd1));
        end
      end
      pcbp_pkg::KIND_FLUSH: begin
        if (acc_count != 0) begin
          tail = {1'b0, acc_bits} << (8 - acc_count);
          r = '{tail, 4'(acc_count), pcbp_pkg::STATUS_PARTIAL, 1'b1};
          predicted_bytes = {predicted_bytes, r};
          acc_bits = '0;
          acc_count = 0;
        end
      end
      default: ;  // reserved kind: nothing
    endcase
  endtask

  task automatic add_item(input logic [1:0] kind, input logic [7:0] sym,
                          input logic [31:0] bits, input logic [5:0] len);
    sym_item_t it;
    it = '{kind, sym, bits, len};
    stim_items = {stim_items, it};
  endtask

  // Mostly short codes, some long, a few past the limit, a few cleared
  function automatic logic [5:0] pick_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return 6'($urandom_range(10, 1));
    if (roll < 85) return 6'($urandom_range(32, 11));
    if (roll < 93) return 6'($urandom_range(63, 33));
    return 6'd0;
  endfunction

  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(99) < 85) return alphabet[$urandom_range(ALPHABET_N - 1)];
    return 8'($urandom_range(255));
  endfunction

  // Driver: present the next word whenever the port is free, with random gaps in the sender phases
  always @(posedge clk_i or negedge rst_ni) begin
    sym_item_t nxt;
    sym_item_t taken;
    int gap_pct;
    if (!rst_ni) begin
      push <= 1'b0;
      phase <= PH_NONE;
    end else begin
      if (push && !full) begin
        taken = '{kind_i, symbol_i, code_bits_i, code_length_i};
        predict_item(taken);
        items_sent++;
      end
      phase <= (total_items == 0) ? PH_NONE : (items_sent * 4) / total_items;
      gap_pct = (phase == PH_SENDER) ? 47 : (phase == PH_BOTH) ? 11 : 0;
      if (!push || !full) begin
        if (stim_items.size() > 0 && $urandom_range(99) >= gap_pct) begin
          nxt = stim_items.pop_front();
          kind_i <= nxt.kind;
          symbol_i <= nxt.symbol;
          code_bits_i <= nxt.code_bits;
          code_length_i <= nxt.code_length;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each popped byte against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    out_byte_t want;
    int stall_pct;
    if (!rst_ni) begin
      pop <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (pop && !empty) begin
        if (predicted_bytes.size() == 0) begin
          $display("%0t: unexpected word byte_out %02h valid_bits %0d status %0d last %0b",
                   $time, byte_out_o, valid_bits_o, status_o, last_o);
          errors++;
        end else begin
          want = predicted_bytes.pop_front();
          if (byte_out_o !== want.byte_val) begin
            $display("%0t: byte_out expected %02h actual %02h",
                     $time, want.byte_val, byte_out_o);
            errors++;
          end
          if (valid_bits_o !== want.valid_bits) begin
            $display("%0t: valid_bits expected %0d actual %0d",
                     $time, want.valid_bits, valid_bits_o);
            errors++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            errors++;
          end
          if (last_o !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, last_o);
            errors++;
          end
        end
        case (status_o)
          pcbp_pkg::STATUS_FULL:    full_seen++;
          pcbp_pkg::STATUS_PARTIAL: partial_seen++;
          pcbp_pkg::STATUS_NOCODE:  nocode_seen++;
          default: ;
        endcase
      end
      stall_pct = (phase == PH_RECEIVE) ? 47 : (phase == PH_BOTH) ? 11 : 0;
      pop <= ($urandom_range(99) >= stall_pct);

      // Watchdog on cycles with no transfer on either side
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT - 1) begin
        $display("%0t: no progress for %0d cycles, %0d words still expected",
                 $time, QUIET_LIMIT, predicted_bytes.size());
        $display("prefix_code_bit_packer verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int made;
    int unsigned roll;
    for (int s = 0; s < pcbp_pkg::SYMBOL_COUNT; s++) begin
      code_word_tbl[s] = '0;
      code_len_tbl[s] = '0;
    end
    acc_bits = '0;
    acc_count = 0;
    items_sent = 0;
    errors = 0;
    full_seen = 0;
    partial_seen = 0;
    nocode_seen = 0;

    // Directed: empty table, saturation, masking, clears, flushes
    add_item(pcbp_pkg::KIND_ENCODE, 8'd0, 32'h0, 6'd0);            // symbol without code
    add_item(pcbp_pkg::KIND_FLUSH, 8'd0, 32'h0, 6'd0);             // nothing pending
    add_item(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);            // reserved kind
    add_item(pcbp_pkg::KIND_LOAD, 8'd0, 32'hFFFF_FFFF, 6'h3F);     // length saturates
    add_item(pcbp_pkg::KIND_LOAD, 8'hFF, 32'hFFFF_FFFD, 6'd3);     // upper bits masked
    add_item(pcbp_pkg::KIND_LOAD, 8'd1, 32'h0, 6'd1);
    add_item(pcbp_pkg::KIND_LOAD, 8'd2, 32'hAAAA_AAAA, 6'd32);
    add_item(pcbp_pkg::KIND_LOAD, 8'd3, 32'h1234_5678, 6'd33);
    add_item(pcbp_pkg::KIND_ENCODE, 8'hFF, 32'h0, 6'd0);           // fills no byte
    add_item(pcbp_pkg::KIND_ENCODE, 8'd0, 32'h0, 6'd0);            // four bytes out
    add_item(pcbp_pkg::KIND_ENCODE, 8'd1, 32'h0, 6'd0);
    add_item(pcbp_pkg::KIND_FLUSH, 8'd0, 32'h0, 6'd0);             // partial byte
    add_item(pcbp_pkg::KIND_ENCODE, 8'd2, 32'h0, 6'd0);            // byte aligned code
    add_item(pcbp_pkg::KIND_ENCODE, 8'd3, 32'h0, 6'd0);
    add_item(pcbp_pkg::KIND_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd0);     // entry cleared
    add_item(pcbp_pkg::KIND_ENCODE, 8'hFF, 32'h0, 6'd0);           // no code, bits kept
    add_item(pcbp_pkg::KIND_LOAD, 8'd128, 32'h7F, 6'd7);
    add_item(pcbp_pkg::KIND_ENCODE, 8'd128, 32'h0, 6'd0);
    add_item(pcbp_pkg::KIND_ENCODE, 8'd128, 32'h0, 6'd0);
    add_item(pcbp_pkg::KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    add_item(pcbp_pkg::KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    add_item(pcbp_pkg::KIND_ENCODE, 8'd3, 32'h0, 6'd0);
    add_item(pcbp_pkg::KIND_FLUSH, 8'd0, 32'h0, 6'd0);

    // Random: build an alphabet, then mostly encode runs over it
    for (int a = 0; a < ALPHABET_N; a++) begin
      alphabet[a] = 8'($urandom_range(255));
      add_item(pcbp_pkg::KIND_LOAD, alphabet[a], $urandom, 6'($urandom_range(12, 1)));
    end
    made = 0;
    while (made < RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        add_item(KIND_UNUSED, 8'($urandom_range(255)), $urandom, 6'($urandom_range(63)));
      end else begin
        if (roll < 18)
          add_item(pcbp_pkg::KIND_LOAD, pick_symbol(), $urandom, pick_length());
        else if (roll < 30)
          add_item(pcbp_pkg::KIND_FLUSH, 8'($urandom_range(255)), $urandom,
                   6'($urandom_range(63)));
        else
          add_item(pcbp_pkg::KIND_ENCODE, pick_symbol(), $urandom, 6'($urandom_range(63)));
        made++;
      end
    end
    total_items = stim_items.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (items_sent == total_items);
    wait (predicted_bytes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d words (loads, encodes, flushes, reserved kinds).", total_items);
    $display("Checked %0d full bytes, %0d partial bytes, %0d missing-code errors.",
             full_seen, partial_seen, nocode_seen);
    if (errors == 0) begin
      $display("prefix_code_bit_packer verification clean");
    end else begin
      $display("prefix_code_bit_packer verification failed");
    end
    $finish;
  end

endmodule
